### hdl/cv3f_pkg.sv
// Shared types and constants for the 3x3 image convolution filter.
package cv3f_pkg;

    // Geometry and field widths
    localparam int MAX_WIDTH_DEF = 1024;
    localparam int PIX_W         = 8;
    localparam int OUT_COL_W     = 10;
    localparam int ROW_W         = 16;
    localparam int FW_W          = 11;
    localparam int COEF_W        = 16;
    localparam int NTAPS         = 9;

    // Configuration port
    localparam int ADDR_W = 6;
    localparam int DATA_W = 64;
    localparam int IDX_W  = 3;

    localparam logic [IDX_W-1:0] REG_FRAME_WIDTH  = 3'd0;
    localparam logic [IDX_W-1:0] REG_FRAME_HEIGHT = 3'd1;
    localparam logic [IDX_W-1:0] REG_COEFFS_LO    = 3'd2;
    localparam logic [IDX_W-1:0] REG_COEFFS_HI    = 3'd3;
    localparam logic [IDX_W-1:0] REG_COEFF_LAST   = 3'd4;

    localparam logic [FW_W-1:0]   RST_FRAME_WIDTH  = 11'd1024;
    localparam logic [ROW_W-1:0]  RST_FRAME_HEIGHT = 16'd768;
    localparam logic [63:0]       RST_COEFFS_LO    = 64'd0;
    localparam logic [63:0]       RST_COEFFS_HI    = 64'd16384;
    localparam logic [COEF_W-1:0] RST_COEFF_LAST   = 16'd0;

    // Arithmetic widths: 8u x 16s product, row sum of three, total of three rows
    localparam int PROD_W = 24;
    localparam int RSUM_W = 26;
    localparam int TSUM_W = 28;
    localparam int FRAC_W = 14;
    localparam int ROUND  = 8192;

    // Result queue
    localparam int FIFO_DEPTH = 8;

    typedef logic [PIX_W-1:0] t_pix;

    typedef struct packed {
        logic [OUT_COL_W-1:0] col;
        logic [ROW_W-1:0]     row;
        logic                 last;
    } t_tag;

    typedef struct packed {
        logic [PIX_W-1:0] value;
        t_tag             tag;
    } t_result;

endpackage

### hdl/conv3x3_image_filter_top.sv
// Top level of the 3x3 convolution filter with its line stores and control.
//
// The filter takes one pixel per cycle while s_axis_tready is high and returns
// at most one filtered pixel per transfer in. After the transfer of the pixel
// that completes its window, a result passes the window register, the MAC
// pipeline and the result queue; that pixel is one row plus one pixel behind
// the input. The rate is set by the two line stores, each read and written
// once per cycle. Behind them sit the window register and the two-register
// multiply-accumulate pipeline. Each accepted transfer reserves a slot in an
// eight-entry result queue, so input continues while the output is stalled
// until eight transfers are outstanding. After reset the line stores are
// cleared while s_axis_tready stays low. Write configuration only while no
// transfer is in flight. After the last pixel of a frame, send frame_width+1
// pad transfers (tuser set) to flush the remaining results.
module conv3x3_image_filter_top #(
    parameter int MAX_WIDTH = cv3f_pkg::MAX_WIDTH_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // Input stream
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    input  logic [7:0]                    s_axis_tdata,  // [7:0] pixel
    input  logic [0:0]                    s_axis_tuser,  // [0] pad
    // Output stream
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    output logic [39:0]                   m_axis_tdata,  // [7:0] value, [17:8] out_column,
                                                         // [33:18] out_row, [39:34] zero
    output logic                          m_axis_tlast,  // frame_end
    // Configuration
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [cv3f_pkg::ADDR_W-1:0]   paddr,
    input  logic [cv3f_pkg::DATA_W-1:0]   pwdata,
    output logic [cv3f_pkg::DATA_W-1:0]   prdata,
    output logic                          pready
);
    import cv3f_pkg::*;

    localparam int CW = $clog2(MAX_WIDTH);
    localparam int WW = $clog2(MAX_WIDTH + 1);
    localparam int EW = (WW > FW_W) ? WW : FW_W;
    localparam int UW = $clog2(FIFO_DEPTH + 1);

    // Configuration registers
    logic [FW_W-1:0]    r_frame_width;
    logic [ROW_W-1:0]   r_frame_height;
    logic [63:0]        r_coeffs_lo;
    logic [63:0]        r_coeffs_hi;
    logic [COEF_W-1:0]  r_coeff_last;
    logic [IDX_W-1:0]   reg_idx;
    logic               cfg_wr;

    // Effective geometry
    logic [EW-1:0]      fw_ext;
    logic [WW-1:0]      w_eff;
    logic [ROW_W-1:0]   h_eff;

    // Position counters
    logic [CW-1:0]      r_in_col;
    logic [ROW_W-1:0]   r_in_row;
    logic [CW-1:0]      r_emit_col;
    logic [ROW_W-1:0]   r_emit_row;

    // Accept-side decode
    logic               acc;
    logic [CW-1:0]      c;
    logic [CW-1:0]      ec;
    logic               emit;
    logic               s0_last;
    logic [2:0]         row_ok;
    logic [2:0]         col_ok;
    logic [NTAPS-1:0]   s0_mask;
    t_pix               s0_px;
    logic               s0_fwd;

    // Line store clearing pass
    logic               r_clr_busy;
    logic [CW-1:0]      r_clr_addr;

    // Line stores and their read registers
    t_pix               r_mem_up [MAX_WIDTH];
    t_pix               r_mem_lo [MAX_WIDTH];
    t_pix               r_up_mem;
    t_pix               r_lo_mem;

    // Window stage
    logic               r_a_valid;
    t_pix               r_a_px;
    logic [CW-1:0]      r_a_col;
    logic               r_a_fwd;
    t_pix               r_a_fup;
    t_pix               r_a_flo;
    logic               r_a_emit;
    logic [NTAPS-1:0]   r_a_mask;
    t_tag               r_a_tag;
    t_pix               a_up;
    t_pix               a_lo;
    t_pix               r_win [3][3];
    logic [NTAPS-1:0][PIX_W-1:0]  taps;
    logic [NTAPS-1:0][COEF_W-1:0] coefs;
    logic               drop;

    // Results
    logic               mac_valid;
    t_result            mac_result;
    logic               fifo_valid;
    t_result            fifo_data;
    logic               pop;
    logic [UW-1:0]      r_used;

    // ---------------------------------------------------------------------
    // Configuration port
    // ---------------------------------------------------------------------
    assign pready  = 1'b1;
    assign reg_idx = paddr[ADDR_W-1:ADDR_W-IDX_W];
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_width  <= RST_FRAME_WIDTH;
            r_frame_height <= RST_FRAME_HEIGHT;
            r_coeffs_lo    <= RST_COEFFS_LO;
            r_coeffs_hi    <= RST_COEFFS_HI;
            r_coeff_last   <= RST_COEFF_LAST;
        end else if (cfg_wr) begin
            case (reg_idx)
                REG_FRAME_WIDTH:  r_frame_width  <= pwdata[FW_W-1:0];
                REG_FRAME_HEIGHT: r_frame_height <= pwdata[ROW_W-1:0];
                REG_COEFFS_LO:    r_coeffs_lo    <= pwdata;
                REG_COEFFS_HI:    r_coeffs_hi    <= pwdata;
                REG_COEFF_LAST:   r_coeff_last   <= pwdata[COEF_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            REG_FRAME_WIDTH:  prdata = DATA_W'(r_frame_width);
            REG_FRAME_HEIGHT: prdata = DATA_W'(r_frame_height);
            REG_COEFFS_LO:    prdata = r_coeffs_lo;
            REG_COEFFS_HI:    prdata = r_coeffs_hi;
            REG_COEFF_LAST:   prdata = DATA_W'(r_coeff_last);
            default:          prdata = '0;
        endcase
    end

    // Width zero acts as one and is capped at the line store depth.
    assign fw_ext = EW'(r_frame_width);

    always_comb begin
        if (r_frame_width == '0) begin
            w_eff = WW'(1);
        end else if (fw_ext > EW'(MAX_WIDTH)) begin
            w_eff = WW'(MAX_WIDTH);
        end else begin
            w_eff = WW'(fw_ext);
        end
    end

    assign h_eff = (r_frame_height == '0) ? ROW_W'(1) : r_frame_height;

    // Kernel taps in row-major order.
    always_comb begin
        for (int k = 0; k < 4; k++) begin
            coefs[k]   = r_coeffs_lo[16*k +: 16];
            coefs[k+4] = r_coeffs_hi[16*k +: 16];
        end
        coefs[8] = r_coeff_last;
    end

    // ---------------------------------------------------------------------
    // Accept decode: positions, emit decision, edge masks
    // ---------------------------------------------------------------------
    assign s_axis_tready = !r_clr_busy && (r_used < UW'(FIFO_DEPTH));
    assign acc           = s_axis_tvalid && s_axis_tready;

    assign c    = (WW'(r_in_col) >= w_eff) ? '0 : r_in_col;
    assign ec   = (WW'(r_emit_col) >= w_eff) ? '0 : r_emit_col;
    assign emit = (r_in_row >= ROW_W'(2)) || ((r_in_row == ROW_W'(1)) && (c != '0));
    assign s0_last = emit && (r_emit_row >= h_eff - 1'b1)
                   && (WW'(ec) >= w_eff - 1'b1);
    assign s0_px = s_axis_tuser[0] ? '0 : s_axis_tdata[PIX_W-1:0];

    // The item leaving the window stage writes the same column this one reads.
    assign s0_fwd = r_a_valid && (r_a_col == c);

    always_comb begin
        row_ok[0] = (r_emit_row != '0) && ((r_emit_row - 1'b1) < h_eff);
        row_ok[1] = (r_emit_row < h_eff);
        row_ok[2] = ((ROW_W+1)'(r_emit_row) + 1'b1) < (ROW_W+1)'(h_eff);
        col_ok[0] = (ec != '0);
        col_ok[1] = 1'b1;
        col_ok[2] = (WW'(ec) + 1'b1) < w_eff;
        for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
                s0_mask[3*i+j] = row_ok[i] && col_ok[j];
            end
        end
    end

    // Position counters update on every accepted transfer and clear at frame end.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_col   <= '0;
            r_in_row   <= '0;
            r_emit_col <= '0;
            r_emit_row <= '0;
        end else if (acc) begin
            if (s0_last) begin
                r_in_col   <= '0;
                r_in_row   <= '0;
                r_emit_col <= '0;
                r_emit_row <= '0;
            end else begin
                if (emit) begin
                    if ((WW'(ec) + 1'b1) >= w_eff) begin
                        r_emit_col <= '0;
                        if (r_emit_row != '1) begin
                            r_emit_row <= r_emit_row + 1'b1;
                        end
                    end else begin
                        r_emit_col <= ec + 1'b1;
                    end
                end else begin
                    r_emit_col <= ec;
                end
                if ((WW'(c) + 1'b1) >= w_eff) begin
                    r_in_col <= '0;
                    if (r_in_row != '1) begin
                        r_in_row <= r_in_row + 1'b1;
                    end
                end else begin
                    r_in_col <= c + 1'b1;
                end
            end
        end
    end

    // ---------------------------------------------------------------------
    // Line stores
    // ---------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_busy <= 1'b1;
            r_clr_addr <= '0;
        end else if (r_clr_busy) begin
            r_clr_addr <= r_clr_addr + 1'b1;
            if (r_clr_addr == CW'(MAX_WIDTH - 1)) begin
                r_clr_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_clr_busy) begin
            r_mem_up[r_clr_addr] <= '0;
            r_mem_lo[r_clr_addr] <= '0;
        end else if (r_a_valid) begin
            r_mem_up[r_a_col] <= a_lo;
            r_mem_lo[r_a_col] <= r_a_px;
        end
        if (acc) begin
            r_up_mem <= r_mem_up[c];
            r_lo_mem <= r_mem_lo[c];
        end
    end

    // ---------------------------------------------------------------------
    // Window stage
    // ---------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else begin
            r_a_valid <= acc;
        end
        if (acc) begin
            r_a_px       <= s0_px;
            r_a_col      <= c;
            r_a_fwd      <= s0_fwd;
            r_a_fup      <= a_lo;
            r_a_flo      <= r_a_px;
            r_a_emit     <= emit;
            r_a_mask     <= s0_mask;
            r_a_tag.col  <= OUT_COL_W'(ec);
            r_a_tag.row  <= r_emit_row;
            r_a_tag.last <= s0_last;
        end
    end

    assign a_up = r_a_fwd ? r_a_fup : r_up_mem;
    assign a_lo = r_a_fwd ? r_a_flo : r_lo_mem;

    // At column zero the new column lies outside the row being filtered.
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            taps[3*i]   = r_a_mask[3*i]   ? r_win[i][1] : '0;
            taps[3*i+1] = r_a_mask[3*i+1] ? r_win[i][2] : '0;
        end
        taps[2] = (r_a_mask[2] && (r_a_col != '0)) ? a_up   : '0;
        taps[5] = (r_a_mask[5] && (r_a_col != '0)) ? a_lo   : '0;
        taps[8] = (r_a_mask[8] && (r_a_col != '0)) ? r_a_px : '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < 3; i++) begin
                for (int j = 0; j < 3; j++) begin
                    r_win[i][j] <= '0;
                end
            end
        end else if (r_a_valid) begin
            for (int i = 0; i < 3; i++) begin
                r_win[i][0] <= r_win[i][1];
                r_win[i][1] <= r_win[i][2];
            end
            r_win[0][2] <= a_up;
            r_win[1][2] <= a_lo;
            r_win[2][2] <= r_a_px;
        end
    end

    // ---------------------------------------------------------------------
    // Arithmetic, result queue and credit count
    // ---------------------------------------------------------------------
    cv3f_mac u_mac (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (r_a_valid && r_a_emit),
        .i_taps   (taps),
        .i_coefs  (coefs),
        .i_tag    (r_a_tag),
        .o_valid  (mac_valid),
        .o_result (mac_result)
    );

    cv3f_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (mac_valid),
        .i_data  (mac_result),
        .i_pop   (m_axis_tready),
        .o_valid (fifo_valid),
        .o_data  (fifo_data)
    );

    assign m_axis_tvalid = fifo_valid;
    assign m_axis_tdata  = {6'd0, fifo_data.tag.row, fifo_data.tag.col, fifo_data.value};
    assign m_axis_tlast  = fifo_data.tag.last;
    assign pop           = m_axis_tvalid && m_axis_tready;

    // Each accepted transfer holds a queue slot until its result leaves or it
    // turns out to produce none.
    assign drop = r_a_valid && !r_a_emit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used <= '0;
        end else begin
            r_used <= r_used + UW'(acc) - UW'(pop) - UW'(drop);
        end
    end

    // ---------------------------------------------------------------------
    // Assertions
    // ---------------------------------------------------------------------
    a_used_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_used <= UW'(FIFO_DEPTH))
        else $error("slot count exceeds queue depth");

    a_out_has_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (r_used != '0))
        else $error("result shown without a reserved slot");

    a_frame_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (acc && s0_last) |=> (r_in_col == '0) && (r_in_row == '0)
                             && (r_emit_col == '0) && (r_emit_row == '0))
        else $error("counters not cleared after frame end");

endmodule

### hdl/cv3f_mac.sv
// Multiply-accumulate pipeline: nine products, three row sums, round and clamp.
module cv3f_mac (
    input  logic                                               i_clk,
    input  logic                                               i_rst_n,
    input  logic                                               i_valid,
    input  logic [cv3f_pkg::NTAPS-1:0][cv3f_pkg::PIX_W-1:0]    i_taps,
    input  logic [cv3f_pkg::NTAPS-1:0][cv3f_pkg::COEF_W-1:0]   i_coefs,
    input  cv3f_pkg::t_tag                                     i_tag,
    output logic                                               o_valid,
    output cv3f_pkg::t_result                                  o_result
);
    import cv3f_pkg::*;

    logic signed [PROD_W-1:0] n_prod [NTAPS];
    logic signed [PROD_W-1:0] r_prod [NTAPS];
    logic                     r_b_valid;
    t_tag                     r_b_tag;

    logic signed [RSUM_W-1:0] n_rsum [3];
    logic signed [RSUM_W-1:0] r_rsum [3];
    logic                     r_c_valid;
    t_tag                     r_c_tag;

    logic signed [TSUM_W-1:0] total;

    // Products of the masked taps with their coefficients.
    always_comb begin
        logic signed [PROD_W:0] p;
        for (int k = 0; k < NTAPS; k++) begin
            p = $signed({1'b0, i_taps[k]}) * $signed(i_coefs[k]);
            n_prod[k] = p[PROD_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
        end else begin
            r_b_valid <= i_valid;
        end
        r_b_tag <= i_tag;
        for (int k = 0; k < NTAPS; k++) begin
            r_prod[k] <= n_prod[k];
        end
    end

    // One sum for each kernel row.
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            n_rsum[i] = RSUM_W'(r_prod[3*i]) + RSUM_W'(r_prod[3*i+1])
                      + RSUM_W'(r_prod[3*i+2]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c_valid <= 1'b0;
        end else begin
            r_c_valid <= r_b_valid;
        end
        r_c_tag <= r_b_tag;
        for (int i = 0; i < 3; i++) begin
            r_rsum[i] <= n_rsum[i];
        end
    end

    // Round half up, then clamp to the pixel range.
    assign total = TSUM_W'(r_rsum[0]) + TSUM_W'(r_rsum[1]) + TSUM_W'(r_rsum[2])
                 + TSUM_W'(ROUND);

    always_comb begin
        o_result.tag = r_c_tag;
        if (total[TSUM_W-1]) begin
            o_result.value = '0;
        end else if (|total[TSUM_W-2:FRAC_W+PIX_W]) begin
            o_result.value = '1;
        end else begin
            o_result.value = total[FRAC_W+PIX_W-1:FRAC_W];
        end
    end

    assign o_valid = r_c_valid;

endmodule

### hdl/cv3f_fifo.sv
// Result queue between the arithmetic pipeline and the output stream.
module cv3f_fifo (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  cv3f_pkg::t_result i_data,
    input  logic              i_pop,
    output logic              o_valid,
    output cv3f_pkg::t_result o_data
);
    import cv3f_pkg::*;

    localparam int AW = $clog2(FIFO_DEPTH);

    t_result           r_slot [FIFO_DEPTH];
    logic [AW-1:0]     r_head;
    logic [AW-1:0]     r_tail;
    logic [AW:0]       r_count;
    logic              do_pop;

    assign do_pop  = i_pop && (r_count != '0);
    assign o_valid = (r_count != '0);
    assign o_data  = r_slot[r_head];

    // Pointers and fill level.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= '0;
            r_tail  <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_tail <= r_tail + 1'b1;
            end
            if (do_pop) begin
                r_head <= r_head + 1'b1;
            end
            r_count <= r_count + (AW+1)'(i_push) - (AW+1)'(do_pop);
        end
    end

    // Storage.
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_tail] <= i_data;
        end
    end

endmodule
